/* src/wsq_pkg.sv */
// Shared types and constants for the wavetable sequencer step unit.
package wsq_pkg;

  // Field widths fixed by the beat formats
  localparam int unsigned POS_W   = 8;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned TIMER_W = 4;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Wave command byte decoding
  localparam logic [BYTE_W-1:0] DELAY_LIMIT = 8'd16;
  localparam logic [BYTE_W-1:0] CMD_FIRST   = 8'hE0;
  localparam logic [BYTE_W-1:0] LOOP_MARK   = 8'hFF;

  // Register reset values
  localparam logic [NOTE_W-1:0] FIRST_NOTE_RST = 7'd0;
  localparam logic [NOTE_W-1:0] LAST_NOTE_RST  = 7'd95;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_WR_WAVE  = 3'd1,
    OP_WR_NOTE  = 3'd2,
    OP_WR_FREQ  = 3'd3,
    OP_START    = 3'd4
  } wsq_op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_NOTE = 1'd0,
    CFG_LAST_NOTE  = 1'd1
  } wsq_cfg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_FREQ
  } wsq_state_t;

  // Input beat
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [7:0]        entry_index;
    logic [FREQ_W-1:0] entry_value;
    logic [POS_W-1:0]  start_position;
    logic [NOTE_W-1:0] start_note;
  } wsq_in_t;

  // Result beat
  typedef struct packed {
    logic              active;
    logic [BYTE_W-1:0] waveform;
    logic [NOTE_W-1:0] note;
    logic [FREQ_W-1:0] frequency;
    logic              vibrato_restart;
  } wsq_out_t;

  // Write request to the table memories
  typedef struct packed {
    logic              wave_we;
    logic              note_we;
    logic              freq_we;
    logic [7:0]        addr;
    logic [FREQ_W-1:0] data;
  } wsq_wr_t;

  // Read data from the wave/note tables: current entry and the one after
  typedef struct packed {
    logic [BYTE_W-1:0] cur_wave;
    logic [BYTE_W-1:0] cur_note;
    logic [BYTE_W-1:0] nxt_wave;
    logic [BYTE_W-1:0] nxt_note;
  } wsq_tbl_rd_t;

endpackage

/* src/wsq_table_mem.sv */
// Wave and note tables: one write port, two registered read ports each.
module wsq_table_mem #(
  parameter int unsigned WAVE_DEPTH = 256
) (
  input  logic                clk,
  input  wsq_pkg::wsq_wr_t    wr,
  input  logic                rd_en,
  input  logic [7:0]          rd_addr_a,
  input  logic [7:0]          rd_addr_b,
  output wsq_pkg::wsq_tbl_rd_t rd
);
  import wsq_pkg::*;

  localparam int unsigned AW = (WAVE_DEPTH > 1) ? $clog2(WAVE_DEPTH) : 1;

  logic [BYTE_W-1:0] wave_mem [WAVE_DEPTH];
  logic [BYTE_W-1:0] note_mem [WAVE_DEPTH];

  logic [BYTE_W-1:0] wave_a_r, note_a_r, wave_b_r, note_b_r;
  logic              in_a_r, in_b_r;
  logic              wr_in, in_a, in_b;

  // Entries beyond the table depth read as zero and ignore writes
  assign wr_in = ({1'b0, wr.addr}   < 9'(WAVE_DEPTH));
  assign in_a  = ({1'b0, rd_addr_a} < 9'(WAVE_DEPTH));
  assign in_b  = ({1'b0, rd_addr_b} < 9'(WAVE_DEPTH));

  // Write port
  always_ff @(posedge clk) begin
    if (wr.wave_we && wr_in) begin
      wave_mem[wr.addr[AW-1:0]] <= wr.data[BYTE_W-1:0];
    end
    if (wr.note_we && wr_in) begin
      note_mem[wr.addr[AW-1:0]] <= wr.data[BYTE_W-1:0];
    end
  end

  // Read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      wave_a_r <= wave_mem[rd_addr_a[AW-1:0]];
      note_a_r <= note_mem[rd_addr_a[AW-1:0]];
      wave_b_r <= wave_mem[rd_addr_b[AW-1:0]];
      note_b_r <= note_mem[rd_addr_b[AW-1:0]];
      in_a_r   <= in_a;
      in_b_r   <= in_b;
    end
  end

  assign rd.cur_wave = in_a_r ? wave_a_r : '0;
  assign rd.cur_note = in_a_r ? note_a_r : '0;
  assign rd.nxt_wave = in_b_r ? wave_b_r : '0;
  assign rd.nxt_note = in_b_r ? note_b_r : '0;

endmodule

/* src/wsq_freq_mem.sv */
// Frequency table: one word per note, registered read.
module wsq_freq_mem #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input  logic                          clk,
  input  wsq_pkg::wsq_wr_t              wr,
  input  logic                          rd_en,
  input  logic [wsq_pkg::NOTE_W-1:0]    rd_addr,
  output logic [wsq_pkg::FREQ_W-1:0]    rd_data
);
  import wsq_pkg::*;

  localparam int unsigned AW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

  logic [FREQ_W-1:0] freq_mem [NOTE_COUNT];
  logic [FREQ_W-1:0] data_r;
  logic              in_r;
  logic              wr_in, rd_in;

  // Notes beyond the table read as zero and ignore writes
  assign wr_in = ({1'b0, wr.addr} < 9'(NOTE_COUNT));
  assign rd_in = ({2'b00, rd_addr} < 9'(NOTE_COUNT));

  always_ff @(posedge clk) begin
    if (wr.freq_we && wr_in) begin
      freq_mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= freq_mem[rd_addr[AW-1:0]];
      in_r   <= rd_in;
    end
  end

  assign rd_data = in_r ? data_r : '0;

endmodule

/* src/wsq_core.sv */
// Sequencer control: playback state, registers, tick decode and note clamping.
module wsq_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wsq_pkg::wsq_in_t              in_beat,
  // result slot
  input  logic                          slot_free,
  output logic                          res_valid,
  output wsq_pkg::wsq_out_t             res_beat,
  // configuration
  input  logic                          cfg_we,
  input  logic [wsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsq_pkg::NOTE_W-1:0]    cfg_data,
  // table memories
  output wsq_pkg::wsq_wr_t              wr,
  output logic                          tbl_rd_en,
  output logic [7:0]                    tbl_addr_a,
  output logic [7:0]                    tbl_addr_b,
  input  wsq_pkg::wsq_tbl_rd_t          tbl_rd,
  output logic                          freq_rd_en,
  output logic [wsq_pkg::NOTE_W-1:0]    freq_addr,
  input  logic [wsq_pkg::FREQ_W-1:0]    freq_data
);
  import wsq_pkg::*;

  wsq_state_t         state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [BYTE_W-1:0]  wave_r, wave_nxt;
  logic [NOTE_W-1:0]  note_r, note_nxt;
  logic [FREQ_W-1:0]  freq_r, freq_nxt;
  logic [NOTE_W-1:0]  first_r, last_r;

  logic               in_fire, restart;
  logic [POS_W-1:0]   pos_inc;
  logic [BYTE_W-1:0]  cmd, nbyte;
  logic [8:0]         rel_sum;
  logic [NOTE_W-1:0]  rel_lo, clamped_note;

  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign pos_inc   = pos_r + POS_W'(1);

  // Both table entries come from the position held at the accepting edge
  assign tbl_rd_en  = in_fire;
  assign tbl_addr_a = pos_r - POS_W'(1);
  assign tbl_addr_b = pos_r;

  assign cmd   = tbl_rd.cur_wave;
  assign nbyte = tbl_rd.cur_note;

  // Note byte: absolute, or offset nbyte - 256 raised to first; then lowered to last
  assign rel_sum = {2'b00, note_r} + {1'b1, nbyte};
  always_comb begin
    if (rel_sum[8] || (rel_sum[7:0] < {1'b0, first_r})) begin
      rel_lo = first_r;
    end else begin
      rel_lo = rel_sum[NOTE_W-1:0];
    end
    if (nbyte[7]) begin
      clamped_note = (rel_lo > last_r) ? last_r : rel_lo;
    end else begin
      clamped_note = (nbyte[NOTE_W-1:0] > last_r) ? last_r : nbyte[NOTE_W-1:0];
    end
  end

  assign freq_addr = clamped_note;

  // Next state and results
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    timer_nxt  = timer_r;
    wave_nxt   = wave_r;
    note_nxt   = note_r;
    freq_nxt   = freq_r;
    res_valid  = 1'b0;
    restart    = 1'b0;
    freq_rd_en = 1'b0;
    wr.wave_we = 1'b0;
    wr.note_we = 1'b0;
    wr.freq_we = 1'b0;
    wr.addr    = in_beat.entry_index;
    wr.data    = in_beat.entry_value;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (wsq_op_t'(in_beat.operation))
            OP_TICK: begin
              if (pos_r == '0) begin
                res_valid = 1'b1;
              end else begin
                state_nxt = S_CMD;
              end
            end
            OP_WR_WAVE: begin
              wr.wave_we = 1'b1;
              res_valid  = 1'b1;
            end
            OP_WR_NOTE: begin
              wr.note_we = 1'b1;
              res_valid  = 1'b1;
            end
            OP_WR_FREQ: begin
              wr.freq_we = 1'b1;
              res_valid  = 1'b1;
            end
            OP_START: begin
              pos_nxt   = in_beat.start_position;
              note_nxt  = in_beat.start_note;
              timer_nxt = '0;
              res_valid = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end

      S_CMD: begin
        if (cmd < DELAY_LIMIT) begin
          // delay entry
          if (cmd[TIMER_W-1:0] == timer_r) begin
            pos_nxt   = pos_inc;
            timer_nxt = '0;
          end else begin
            timer_nxt = timer_r + TIMER_W'(1);
          end
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end else if ((cmd >= CMD_FIRST) && (cmd != LOOP_MARK)) begin
          // unsupported command: skip
          pos_nxt   = pos_inc;
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // waveform entry or loop marker
          if (cmd < CMD_FIRST) begin
            wave_nxt = cmd - DELAY_LIMIT;
          end
          pos_nxt   = (tbl_rd.nxt_wave == LOOP_MARK) ? tbl_rd.nxt_note : pos_inc;
          timer_nxt = '0;
          if (nbyte == '0) begin
            res_valid = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            note_nxt   = clamped_note;
            freq_rd_en = 1'b1;
            state_nxt  = S_FREQ;
          end
        end
      end

      S_FREQ: begin
        freq_nxt  = freq_data;
        restart   = 1'b1;
        res_valid = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_beat.active          = (pos_nxt != '0);
    res_beat.waveform        = wave_nxt;
    res_beat.note            = note_nxt;
    res_beat.frequency       = freq_nxt;
    res_beat.vibrato_restart = restart;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      timer_r <= '0;
      wave_r  <= '0;
      note_r  <= '0;
      freq_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      timer_r <= timer_nxt;
      wave_r  <= wave_nxt;
      note_r  <= note_nxt;
      freq_r  <= freq_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= FIRST_NOTE_RST;
      last_r  <= LAST_NOTE_RST;
    end else if (cfg_we) begin
      unique case (wsq_cfg_t'(cfg_index))
        CFG_FIRST_NOTE: first_r <= cfg_data;
        CFG_LAST_NOTE:  last_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/wavetable_sequencer_step_unit.sv */
// Top level of the wavetable sequencer step unit: tables, control and result register.
//
// Input beats arrive on in_valid/in_ready/in_beat. Write beats (wave, note,
// frequency entry), start beats, unused operation codes and frame ticks on a
// stopped voice are answered from the idle state and are accepted back to
// back while the receiver does not stall. Any other frame tick reads the
// current and the next table entry from the wave/note memory (state S_CMD)
// and, when it applies a note, the frequency memory (state S_FREQ), the two
// reads in series. Each input beat yields exactly one result beat on
// out_valid/out_ready/out_beat, held in an output register;
// the result appears the cycle after the last step of its item.
// A new input beat is taken while a result waits, as long as that result is
// taken in the same cycle; if the receiver stalls, in_ready drops until the
// result register drains. Configuration writes on cfg_valid/cfg_index/cfg_data
// are always taken (cfg_ready high), and must only come while the unit is idle.
// Synchronous reset (rst_n low) stops playback, clears waveform, note,
// frequency and delay timer and restores the note limits (0 and 95). Table
// contents are not cleared and must be written before they are played.
module wavetable_sequencer_step_unit #(
  parameter int unsigned WAVE_DEPTH = 256,
  parameter int unsigned NOTE_COUNT = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wsq_pkg::wsq_in_t              in_beat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wsq_pkg::wsq_out_t             out_beat,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsq_pkg::NOTE_W-1:0]    cfg_data
);
  import wsq_pkg::*;

  wsq_wr_t           wr;
  wsq_tbl_rd_t       tbl_rd;
  logic              tbl_rd_en, freq_rd_en;
  logic [7:0]        tbl_addr_a, tbl_addr_b;
  logic [NOTE_W-1:0] freq_addr;
  logic [FREQ_W-1:0] freq_data;
  logic              slot_free, res_valid;
  wsq_out_t          res_beat;
  logic              out_valid_r;
  wsq_out_t          out_beat_r;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;

  wsq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res_beat   (res_beat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr         (wr),
    .tbl_rd_en  (tbl_rd_en),
    .tbl_addr_a (tbl_addr_a),
    .tbl_addr_b (tbl_addr_b),
    .tbl_rd     (tbl_rd),
    .freq_rd_en (freq_rd_en),
    .freq_addr  (freq_addr),
    .freq_data  (freq_data)
  );

  wsq_table_mem #(
    .WAVE_DEPTH (WAVE_DEPTH)
  ) u_table_mem (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (tbl_rd_en),
    .rd_addr_a (tbl_addr_a),
    .rd_addr_b (tbl_addr_b),
    .rd        (tbl_rd)
  );

  wsq_freq_mem #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_freq_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (freq_rd_en),
    .rd_addr (freq_addr),
    .rd_data (freq_data)
  );

  // Result register: loads only when free or draining this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_beat_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

/* tb/wavetable_sequencer_step_unit_tb.sv */
// Self-checking testbench for the wavetable sequencer step unit.
module wavetable_sequencer_step_unit_tb;
  import wsq_pkg::*;

  // Operation codes the unit leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  wsq_in_t              in_beat;
  logic                 out_valid;
  logic                 out_ready;
  wsq_out_t             out_beat;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NOTE_W-1:0]    cfg_data;

  // Mirror of the voice: limits, playback state and the three stores
  logic [NOTE_W-1:0]  lo_note;
  logic [NOTE_W-1:0]  hi_note;
  logic [POS_W-1:0]   play_pos;
  logic [TIMER_W-1:0] dly_count;
  logic [BYTE_W-1:0]  wave_now;
  logic [NOTE_W-1:0]  note_now;
  logic [FREQ_W-1:0]  freq_now;
  logic [BYTE_W-1:0]  wave_mem [256];
  logic [BYTE_W-1:0]  note_mem [256];
  logic [FREQ_W-1:0]  freq_mem [128];
  bit                 wave_set [256];
  bit                 note_set [256];
  bit                 freq_set [128];

  wsq_out_t    pending_steps [$];
  int unsigned beats_sent;
  int unsigned steps_seen;
  int unsigned fail_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  wavetable_sequencer_step_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Note byte applied to the current note: absolute, or a downward offset
  function automatic logic [NOTE_W-1:0] next_note(input logic [NOTE_W-1:0] cur,
                                                  input logic [BYTE_W-1:0] nb);
    int rel;
    if (nb[7]) begin
      rel = int'(cur) + int'(nb) - 256;
      if (rel < int'(lo_note)) rel = int'(lo_note);
      if (rel > int'(hi_note)) rel = int'(hi_note);
      return rel[NOTE_W-1:0];
    end
    return (nb[NOTE_W-1:0] > hi_note) ? hi_note : nb[NOTE_W-1:0];
  endfunction

  // Apply one accepted input beat to the mirror and return the result beat
  function automatic wsq_out_t step_voice(input wsq_in_t b);
    wsq_out_t          r;
    logic [POS_W-1:0]  here;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] nb;
    logic              fresh;
    fresh = 1'b0;
    case (b.operation)
      OP_TICK: if (play_pos != '0) begin
        here = play_pos - 8'd1;
        cmd  = wave_mem[here];
        if (cmd < DELAY_LIMIT) begin
          // delay: hold until the timer reaches the entry's count
          if (cmd[TIMER_W-1:0] == dly_count) begin
            play_pos  = play_pos + 8'd1;
            dly_count = '0;
          end else begin
            dly_count = dly_count + 4'd1;
          end
        end else if (cmd >= CMD_FIRST && cmd != LOOP_MARK) begin
          play_pos = play_pos + 8'd1;
        end else begin
          // waveform entry or loop marker in the current entry
          if (cmd < CMD_FIRST) wave_now = cmd - DELAY_LIMIT;
          nb = note_mem[here];
          if (wave_mem[play_pos] == LOOP_MARK) play_pos = note_mem[play_pos];
          else play_pos = play_pos + 8'd1;
          dly_count = '0;
          if (nb != '0) begin
            note_now = next_note(note_now, nb);
            freq_now = freq_mem[note_now];
            fresh    = 1'b1;
          end
        end
      end
      OP_WR_WAVE: begin
        wave_mem[b.entry_index] = b.entry_value[BYTE_W-1:0];
        wave_set[b.entry_index] = 1'b1;
      end
      OP_WR_NOTE: begin
        note_mem[b.entry_index] = b.entry_value[BYTE_W-1:0];
        note_set[b.entry_index] = 1'b1;
      end
      OP_WR_FREQ: if (b.entry_index < $size(freq_mem)) begin
        freq_mem[b.entry_index] = b.entry_value;
        freq_set[b.entry_index] = 1'b1;
      end
      OP_START: begin
        play_pos  = b.start_position;
        note_now  = b.start_note;
        dly_count = '0;
      end
      default: ;
    endcase
    r.active          = (play_pos != '0);
    r.waveform        = wave_now;
    r.note            = note_now;
    r.frequency       = freq_now;
    r.vibrato_restart = fresh;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR result %0d: %s", steps_seen, what);
    fail_count++;
  endtask

  task automatic check_step(input wsq_out_t got);
    wsq_out_t want;
    steps_seen++;
    if (pending_steps.size() == 0) begin
      report_mismatch($sformatf("result beat with none expected: %p", got));
      return;
    end
    want = pending_steps.pop_front();
    if (got.active !== want.active)
      report_mismatch($sformatf("active %b, want %b", got.active, want.active));
    if (got.waveform !== want.waveform)
      report_mismatch($sformatf("waveform %h, want %h", got.waveform, want.waveform));
    if (got.note !== want.note)
      report_mismatch($sformatf("note %0d, want %0d", got.note, want.note));
    if (got.frequency !== want.frequency)
      report_mismatch($sformatf("frequency %h, want %h", got.frequency, want.frequency));
    if (got.vibrato_restart !== want.vibrato_restart)
      report_mismatch($sformatf("vibrato_restart %b, want %b",
                                got.vibrato_restart, want.vibrato_restart));
  endtask

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_step(out_beat);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one input beat; valid stays high from the previous beat unless we gap
  task automatic send_beat(input wsq_in_t b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
    pending_steps.push_back(step_voice(b));
    beats_sent++;
  endtask

  // Hold off the input side until every result has come back
  task automatic drain_steps();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_steps.size() != 0);
  endtask

  task automatic write_limit(input wsq_cfg_t sel, input logic [NOTE_W-1:0] val);
    drain_steps();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == CFG_FIRST_NOTE) lo_note = val;
    else hi_note = val;
  endtask

  function automatic logic [BYTE_W-1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 8'($urandom_range(15, 0));
    if (r < 40) return 8'($urandom_range(8'hFE, 8'hE0));
    if (r < 88) return 8'($urandom_range(8'hDF, 8'h10));
    return LOOP_MARK;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_note_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 8'h00;
    if (r < 60) return 8'($urandom_range(127, 1));
    if (r < 80) return 8'($urandom_range(8'hFF, 8'hF0));
    return 8'($urandom_range(8'hFF, 8'h80));
  endfunction

  // Table write; wave and note entries carry random junk in the upper byte
  task automatic store_entry(input logic [OP_W-1:0] op, input logic [7:0] idx,
                             input logic [FREQ_W-1:0] val);
    wsq_in_t b;
    b.operation      = op;
    b.entry_index    = idx;
    b.entry_value    = (op == OP_WR_FREQ) ? val : {8'($urandom), val[BYTE_W-1:0]};
    b.start_position = 8'($urandom);
    b.start_note     = 7'($urandom);
    send_beat(b);
  endtask

  task automatic start_voice(input logic [POS_W-1:0] pos, input logic [NOTE_W-1:0] nt);
    wsq_in_t b;
    b.operation      = OP_START;
    b.entry_index    = 8'($urandom);
    b.entry_value    = 16'($urandom);
    b.start_position = pos;
    b.start_note     = nt;
    send_beat(b);
  endtask

  // Frame tick; any entry it reads that was never written is loaded first
  task automatic tick_beat();
    logic [POS_W-1:0]  here;
    logic [BYTE_W-1:0] cmd;
    logic [NOTE_W-1:0] nn;
    wsq_in_t           b;
    if (play_pos != '0) begin
      here = play_pos - 8'd1;
      if (!wave_set[here]) store_entry(OP_WR_WAVE, here, {8'h00, pick_cmd()});
      if (!note_set[here]) store_entry(OP_WR_NOTE, here, {8'h00, pick_note_byte()});
      if (!wave_set[play_pos]) store_entry(OP_WR_WAVE, play_pos, {8'h00, pick_cmd()});
      if (!note_set[play_pos]) store_entry(OP_WR_NOTE, play_pos, 16'($urandom));
      cmd = wave_mem[here];
      if (cmd >= DELAY_LIMIT && (cmd < CMD_FIRST || cmd == LOOP_MARK) &&
          note_mem[here] != '0) begin
        nn = next_note(note_now, note_mem[here]);
        if (!freq_set[nn]) store_entry(OP_WR_FREQ, {1'b0, nn}, 16'($urandom));
      end
    end
    b.operation      = OP_TICK;
    b.entry_index    = 8'($urandom);
    b.entry_value    = 16'($urandom);
    b.start_position = 8'($urandom);
    b.start_note     = 7'($urandom);
    send_beat(b);
  endtask

  // Any operation code with random fields
  task automatic noise_beat();
    wsq_in_t b;
    b.operation      = 3'($urandom_range(7, 0));
    b.entry_index    = 8'($urandom);
    b.entry_value    = 16'($urandom);
    b.start_position = 8'($urandom);
    b.start_note     = 7'($urandom);
    if (b.operation == OP_TICK) tick_beat();
    else send_beat(b);
  endtask

  // Short looping program at a random base, started and played for a while
  task automatic play_program();
    int unsigned len;
    int unsigned base;
    int unsigned runs;
    int unsigned r;
    len  = $urandom_range(8, 2);
    base = $urandom_range(255 - len, 0);
    for (int unsigned k = 0; k < len; k++) begin
      store_entry(OP_WR_WAVE, 8'(base + k), {8'h00, pick_cmd()});
      store_entry(OP_WR_NOTE, 8'(base + k), {8'h00, pick_note_byte()});
    end
    store_entry(OP_WR_WAVE, 8'(base + len), {8'h00, LOOP_MARK});
    if ($urandom_range(99) < 85) store_entry(OP_WR_NOTE, 8'(base + len), 16'(base + 1));
    else store_entry(OP_WR_NOTE, 8'(base + len), 16'($urandom));
    start_voice(8'(base + 1), 7'($urandom));
    runs = $urandom_range(40, 8);
    repeat (runs) begin
      r = $urandom_range(99);
      // now and then rewrite the current entry mid-delay, or throw in noise
      if (r < 5 && play_pos != '0)
        store_entry(OP_WR_WAVE, play_pos - 8'd1, {8'h00, pick_cmd()});
      else if (r < 12)
        noise_beat();
      tick_beat();
    end
  endtask

  task automatic test_unused_ops();
    wsq_in_t b;
    b           = '0;
    b.operation = OP_SPARE_LO;
    send_beat(b);
    b           = '1;
    b.operation = OP_SPARE_HI;
    send_beat(b);
  endtask

  // Advance from the last position wraps to stopped; out-of-range frequency write
  task automatic test_position_wrap();
    store_entry(OP_WR_WAVE, 8'd254, 16'h0010);
    store_entry(OP_WR_NOTE, 8'd254, 16'h007F);
    store_entry(OP_WR_WAVE, 8'd255, 16'h0005);
    store_entry(OP_WR_NOTE, 8'd255, 16'h0080);
    store_entry(OP_WR_FREQ, 8'd95, 16'hFFFF);
    store_entry(OP_WR_FREQ, 8'd200, 16'h0000);
    start_voice(8'd255, 7'd0);
    tick_beat();
    tick_beat();
    start_voice(8'd0, 7'd127);
  endtask

  // Delay, command skip, waveform with loop, then a loop marker as current entry
  task automatic test_command_walk();
    store_entry(OP_WR_WAVE, 8'd0, 16'h0002);
    store_entry(OP_WR_NOTE, 8'd0, 16'h0000);
    store_entry(OP_WR_WAVE, 8'd1, 16'h00E0);
    store_entry(OP_WR_NOTE, 8'd1, 16'h0000);
    store_entry(OP_WR_WAVE, 8'd2, 16'h00DF);
    store_entry(OP_WR_NOTE, 8'd2, 16'h0081);
    store_entry(OP_WR_WAVE, 8'd3, {8'h00, LOOP_MARK});
    store_entry(OP_WR_NOTE, 8'd3, 16'h0004);
    store_entry(OP_WR_FREQ, 8'd0, 16'h8001);
    start_voice(8'd1, 7'd127);
    repeat (7) tick_beat();
  endtask

  // Lower note limit above the upper one: the upper limit wins
  task automatic test_inverted_limits();
    write_limit(CFG_FIRST_NOTE, 7'd127);
    write_limit(CFG_LAST_NOTE, 7'd0);
    store_entry(OP_WR_WAVE, 8'd10, 16'h0020);
    store_entry(OP_WR_NOTE, 8'd10, 16'h0090);
    store_entry(OP_WR_WAVE, 8'd11, 16'h0030);
    store_entry(OP_WR_NOTE, 8'd11, 16'h0050);
    store_entry(OP_WR_WAVE, 8'd12, {8'h00, LOOP_MARK});
    store_entry(OP_WR_NOTE, 8'd12, 16'd11);
    start_voice(8'd11, 7'd64);
    repeat (3) tick_beat();
  endtask

  task automatic test_random_play(input int unsigned quota);
    int unsigned stop_at;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      if ($urandom_range(99) < 65) play_program();
      else noise_beat();
      if ($urandom_range(99) < 3) drain_steps();
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_beat        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_FIRST_NOTE;
    cfg_data       = '0;
    lo_note        = FIRST_NOTE_RST;
    hi_note        = LAST_NOTE_RST;
    play_pos       = '0;
    dly_count      = '0;
    wave_now       = '0;
    note_now       = '0;
    freq_now       = '0;
    beats_sent     = 0;
    steps_seen     = 0;
    fail_count     = 0;
    send_gap_pct   = 9;
    recv_stall_pct = 49;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unused_ops();
    test_position_wrap();
    test_command_walk();
    test_inverted_limits();

    write_limit(CFG_FIRST_NOTE, 7'd0);
    write_limit(CFG_LAST_NOTE, 7'd127);
    test_random_play(160);

    send_gap_pct   = 49;
    recv_stall_pct = 9;
    write_limit(CFG_FIRST_NOTE, 7'($urandom_range(60, 0)));
    write_limit(CFG_LAST_NOTE, 7'($urandom_range(127, 60)));
    test_random_play(160);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_limit(CFG_FIRST_NOTE, 7'($urandom));
    write_limit(CFG_LAST_NOTE, 7'($urandom));
    test_random_play(160);

    drain_steps();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("wavetable_sequencer_step_unit: match");
    else $display("wavetable_sequencer_step_unit: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("wavetable_sequencer_step_unit: mismatch");
    $finish;
  end

endmodule

/* sim.f */
src/wsq_pkg.sv
src/wsq_table_mem.sv
src/wsq_freq_mem.sv
src/wsq_core.sv
src/wavetable_sequencer_step_unit.sv
tb/wavetable_sequencer_step_unit_tb.sv
